// ===== hw/rtl/arp_pkg.sv =====
// Shared types, relocation type codes and constants for the ARM32 relocation patcher.
`timescale 1ns / 1ps

package arp_pkg;

  localparam int TABLE_WORDS_MAX = 1024;
  localparam int VENEER_WORDS    = 3;
  localparam int FILL_W          = 11;
  localparam int CFG_IDX_W       = 2;

  localparam logic [7:0] R_NONE      = 8'd0;
  localparam logic [7:0] R_PC24      = 8'd1;
  localparam logic [7:0] R_ABS32     = 8'd2;
  localparam logic [7:0] R_REL32     = 8'd3;
  localparam logic [7:0] R_GLOB_DAT  = 8'd21;
  localparam logic [7:0] R_JUMP_SLOT = 8'd22;
  localparam logic [7:0] R_GOTPC     = 8'd25;
  localparam logic [7:0] R_GOT32     = 8'd26;
  localparam logic [7:0] R_CALL      = 8'd28;
  localparam logic [7:0] R_JUMP24    = 8'd29;
  localparam logic [7:0] R_TARGET1   = 8'd38;
  localparam logic [7:0] R_V4BX      = 8'd40;
  localparam logic [7:0] R_PREL31    = 8'd42;
  localparam logic [7:0] R_MOVW_ABS  = 8'd43;
  localparam logic [7:0] R_MOVT_ABS  = 8'd44;
  localparam logic [7:0] R_MOVW_PREL = 8'd45;
  localparam logic [7:0] R_MOVT_PREL = 8'd46;
  localparam logic [7:0] R_GOT_PREL  = 8'd96;

  localparam logic [CFG_IDX_W-1:0] CFG_PLT_ENABLE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TABLE_BASE  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TABLE_LIMIT = 2'd2;

  localparam logic [31:0] VENEER_LDR = 32'hE59FC000;
  localparam logic [31:0] VENEER_MOV = 32'hE1A0F00C;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_UNSUP = 2'd1,
    ST_THUMB = 2'd2,
    ST_OVF   = 2'd3
  } status_t;

  typedef struct packed {
    logic [31:0] word;
    logic [31:0] write_addr;
    logic        to_table;
    status_t     status;
    logic        last;
  } beat_t;

  typedef struct packed {
    logic              plt_enable;
    logic [31:0]       table_base;
    logic [FILL_W-1:0] table_limit_words;
  } cfg_t;

  function automatic logic branch_in_range(input logic [31:0] x);
    return (x[31:25] == 7'h00) || ((x[31:25] == 7'h7f) && (x[24:0] != 25'd0));
  endfunction

endpackage

// ===== hw/rtl/arp_calc.sv =====
// Relocation arithmetic and beat selection for the item held in the input register.
`timescale 1ns / 1ps

module arp_calc (
  input  logic [7:0]                 func,
  input  logic [31:0]                orig_word,
  input  logic [31:0]                sym_value,
  input  logic [31:0]                place_addr,
  input  logic [31:0]                got_entry_addr,
  input  arp_pkg::cfg_t              cfg,
  input  logic [arp_pkg::FILL_W-1:0] fill,
  input  logic [1:0]                 beat_idx,
  output arp_pkg::beat_t             beat,
  output logic                       veneer
);
  import arp_pkg::*;

  logic [31:0]       w;
  logic [31:0]       off1;
  logic [31:0]       off2;
  logic [31:0]       ven;
  logic [31:0]       ven_target;
  logic [FILL_W:0]   fill_sum;
  logic [FILL_W:0]   lim;
  logic              use_ven;
  logic              full;
  logic [31:0]       prel_v;
  logic [31:0]       mov_v;
  logic [15:0]       mov_h;
  logic [31:0]       r;
  status_t           st;

  assign w = orig_word;

  assign off1 = {{6{w[23]}}, w[23:0], 2'b00} + sym_value - place_addr;
  assign use_ven = cfg.plt_enable && !branch_in_range(off1);
  assign fill_sum = {1'b0, fill} + (FILL_W + 1)'(VENEER_WORDS);
  assign lim = ({1'b0, cfg.table_limit_words} > (FILL_W + 1)'(TABLE_WORDS_MAX)) ?
               (FILL_W + 1)'(TABLE_WORDS_MAX) : {1'b0, cfg.table_limit_words};
  assign full = fill_sum > lim;
  assign ven = cfg.table_base + {{(32 - FILL_W - 2){1'b0}}, fill, 2'b00};
  assign off2 = use_ven ? (ven - place_addr - 32'd8) : off1;
  assign ven_target = off1 + place_addr + 32'd8;

  assign prel_v = {w[30], w[30:0]} + sym_value - place_addr;

  always_comb begin
    mov_v = {{16{w[19]}}, w[19:16], w[11:0]} + sym_value;
    if (func == R_MOVW_PREL || func == R_MOVT_PREL) begin
      mov_v = mov_v - place_addr;
    end
    mov_h = (func == R_MOVT_ABS || func == R_MOVT_PREL) ? mov_v[31:16] : mov_v[15:0];
  end

  always_comb begin
    r = w;
    st = ST_OK;
    veneer = 1'b0;
    unique case (func)
      R_NONE: begin
        r = w;
      end
      R_ABS32, R_TARGET1, R_GLOB_DAT, R_JUMP_SLOT: begin
        r = w + sym_value;
      end
      R_REL32: begin
        r = w + sym_value - place_addr;
      end
      R_PC24, R_CALL, R_JUMP24: begin
        priority if (sym_value[1:0] != 2'b00) begin
          st = ST_THUMB;
        end else if (use_ven && full) begin
          st = ST_OVF;
        end else begin
          veneer = use_ven;
          if (!branch_in_range(off2)) begin
            st = ST_OVF;
          end
          r = {w[31:24], off2[25:2]};
        end
      end
      R_V4BX: begin
        r = (w & 32'hf000000f) | 32'h01a0f000;
      end
      R_PREL31: begin
        if (prel_v[31] != prel_v[30]) begin
          st = ST_OVF;
        end
        r = {w[31], prel_v[30:0]};
      end
      R_MOVW_ABS, R_MOVT_ABS, R_MOVW_PREL, R_MOVT_PREL: begin
        r = {w[31:20], mov_h[15:12], w[15:12], mov_h[11:0]};
      end
      R_GOTPC: begin
        r = w + cfg.table_base - place_addr;
      end
      R_GOT32, R_GOT_PREL: begin
        if (got_entry_addr == 32'd0) begin
          st = ST_OVF;
        end
        r = w + got_entry_addr - ((func == R_GOT32) ? cfg.table_base : place_addr);
      end
      default: begin
        st = ST_UNSUP;
      end
    endcase
  end

  always_comb begin
    beat.word       = (st == ST_OK) ? r : w;
    beat.write_addr = 32'd0;
    beat.to_table   = 1'b0;
    beat.status     = st;
    beat.last       = 1'b1;
    if (veneer && beat_idx != 2'd3) begin
      beat.write_addr = ven + {28'd0, beat_idx, 2'b00};
      beat.to_table   = 1'b1;
      beat.status     = ST_OK;
      beat.last       = 1'b0;
      unique case (beat_idx)
        2'd0:    beat.word = VENEER_LDR;
        2'd1:    beat.word = VENEER_MOV;
        default: beat.word = ven_target;
      endcase
    end
  end

endmodule

// ===== hw/rtl/arp_oreg.sv =====
// Output register for result beats with valid/stall handshake.
`timescale 1ns / 1ps

module arp_oreg (
  input  logic           clk,
  input  logic           rst,
  input  logic           load,
  input  arp_pkg::beat_t beat_in,
  input  logic           out_stall,
  output logic           free,
  output logic           out_valid,
  output arp_pkg::beat_t beat_out
);
  import arp_pkg::*;

  assign free = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (free) begin
      out_valid <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (free && load) begin
      beat_out <= beat_in;
    end
  end

endmodule

// ===== hw/rtl/arm32_elf_relocation_patcher.sv =====
// Top level of the ARM32 REL relocation patcher: input register, table fill count, config.
// A relocation is held in the input register and each result beat in the output register.
// Throughput: one relocation per cycle unless the output stalls; a branch routed through
// a veneer holds the input register for four beats (three veneer words, the place word).
// Reset clears the config registers, the table fill count and both valid flags.
`timescale 1ns / 1ps

module arm32_elf_relocation_patcher (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [arp_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]                   cfg_data,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [7:0]                    func,
  input  logic [31:0]                   orig_word,
  input  logic [31:0]                   sym_value,
  input  logic [31:0]                   place_addr,
  input  logic [31:0]                   got_entry_addr,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [31:0]                   word,
  output logic [31:0]                   write_addr,
  output logic                          to_table,
  output logic [1:0]                    status,
  output logic                          last
);
  import arp_pkg::*;

  cfg_t              cfg;
  logic [FILL_W-1:0] fill;
  logic              a_valid;
  logic [1:0]        beat_idx;
  logic [7:0]        a_func;
  logic [31:0]       a_word;
  logic [31:0]       a_sym;
  logic [31:0]       a_place;
  logic [31:0]       a_got;
  beat_t             beat;
  beat_t             obeat;
  logic              veneer;
  logic              free;
  logic              take;
  logic              done;
  logic              in_take;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_PLT_ENABLE:  cfg.plt_enable <= cfg_data[0];
        CFG_TABLE_BASE:  cfg.table_base <= cfg_data;
        CFG_TABLE_LIMIT: cfg.table_limit_words <= cfg_data[FILL_W-1:0];
        default: ;
      endcase
    end
  end

  arp_calc u_calc (
    .func           (a_func),
    .orig_word      (a_word),
    .sym_value      (a_sym),
    .place_addr     (a_place),
    .got_entry_addr (a_got),
    .cfg            (cfg),
    .fill           (fill),
    .beat_idx       (beat_idx),
    .beat           (beat),
    .veneer         (veneer)
  );

  assign take     = a_valid && free;
  assign done     = take && beat.last;
  assign in_stall = a_valid && !done;
  assign in_take  = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid  <= 1'b0;
      beat_idx <= 2'd0;
      fill     <= '0;
    end else begin
      if (done) begin
        beat_idx <= 2'd0;
        if (veneer) begin
          fill <= fill + FILL_W'(VENEER_WORDS);
        end
      end else if (take) begin
        beat_idx <= beat_idx + 2'd1;
      end
      if (in_take) begin
        a_valid <= 1'b1;
      end else if (done) begin
        a_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      a_func  <= func;
      a_word  <= orig_word;
      a_sym   <= sym_value;
      a_place <= place_addr;
      a_got   <= got_entry_addr;
    end
  end

  arp_oreg u_oreg (
    .clk       (clk),
    .rst       (rst),
    .load      (a_valid),
    .beat_in   (beat),
    .out_stall (out_stall),
    .free      (free),
    .out_valid (out_valid),
    .beat_out  (obeat)
  );

  assign word       = obeat.word;
  assign write_addr = obeat.write_addr;
  assign to_table   = obeat.to_table;
  assign status     = obeat.status;
  assign last       = obeat.last;

  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill <= FILL_W'(TABLE_WORDS_MAX))
    else $error("table fill count beyond table size");

  a_veneer_beat: assert property (@(posedge clk) disable iff (rst)
    out_valid && to_table |-> !last && status == ST_OK)
    else $error("veneer beat marked last or with error status");

  a_error_beat: assert property (@(posedge clk) disable iff (rst)
    out_valid && status != ST_OK |-> last && !to_table && write_addr == 32'd0)
    else $error("error beat not a final place beat");

  a_fill_step: assert property (@(posedge clk) disable iff (rst)
    !done |=> $stable(fill))
    else $error("fill count moved without a finished relocation");

endmodule
